[rtl/bresenham_line_rasterizer_macros.svh]
// Assertion macros for the line rasterizer.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLR_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("blr assertion failed");

// Next-cycle implication, disabled during reset.
`define BLR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("blr assertion failed");

`endif

[rtl/blr_pkg.sv]
// Shared types and constants for the line rasterizer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS = 6;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } blr_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } blr_cmd_t;

  typedef struct packed {
    logic span_zero;
    logic at_last;
  } blr_status_t;

endpackage

`default_nettype wire

[rtl/bresenham_line_rasterizer.sv]
// Line rasterizer on a 64 by 64 tile: one segment in, one pixel per step out.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one segment as two
//   endpoints. Output channel (out_valid_o / out_stall_i) gives one item per
//   plotted pixel; last_pixel_o marks the final pixel of the segment.
//   The endpoint with the lower major coordinate is drawn, the other is not;
//   a segment gives as many pixels as its major span, a zero-length one none.
// Timing:
//   The first pixel is valid once the controller has entered its run state
//   and a step has written the output register. Pixels follow at one per
//   cycle while the receiver does not stall; a zero-length segment leaves
//   the block idle. The rate is set by the single error-stepping loop in the
//   datapath. The next segment is taken in the cycle after the last pixel
//   enters the output register, while that pixel may still wait to be taken.
// Stall and reset:
//   A stalled output holds its item and stepping pauses. Reset is
//   asynchronous, active low, and leaves the block idle with no item shown.
// Depends on blr_pkg, blr_ctrl, blr_datapath and the assertion macro header.
`default_nettype none

`include "bresenham_line_rasterizer_macros.svh"

module bresenham_line_rasterizer
  import blr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  input  wire coord_t start_x_i,
  input  wire coord_t start_y_i,
  input  wire coord_t end_x_i,
  input  wire coord_t end_y_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output coord_t      pixel_x_o,
  output coord_t      pixel_y_o,
  output logic        last_pixel_o
);

  blr_cmd_t    cmd;
  blr_status_t status;

  blr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  blr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  `BLR_ASSERT_NEXT(a_busy_after_load, clk_i, rst_ni, in_valid_i && !in_stall_o && !status.span_zero, in_stall_o)
  `BLR_ASSERT_NEXT(a_hold_when_stalled, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable({pixel_x_o, pixel_y_o, last_pixel_o}))
  `BLR_ASSERT_IMPLIES(a_no_step_when_open, clk_i, rst_ni, !in_stall_o, !cmd.step)

endmodule

`default_nettype wire

[rtl/blr_datapath.sv]
// Datapath of the line rasterizer: endpoint ordering, span setup, error
// stepping and the pixel output register. Depends on blr_pkg.
`default_nettype none

module blr_datapath
  import blr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire blr_cmd_t    cmd_i,
  output blr_status_t      status_o,
  input  wire coord_t      start_x_i,
  input  wire coord_t      start_y_i,
  input  wire coord_t      end_x_i,
  input  wire coord_t      end_y_i,
  output coord_t           pixel_x_o,
  output coord_t           pixel_y_o,
  output logic             last_pixel_o
);

  coord_t dx, dy, sx, sy, ex, ey;
  coord_t maj0, majend, mnr0, mnrend, mspan, nspan;
  logic   steep, swap;
  err_t   err0;

  coord_t maj_q, major_end_q, mnr_q, major_span_q, minor_span_q;
  logic   minor_negative_q, steep_line_q;
  err_t   err_q;
  coord_t pixel_x_q, pixel_y_q;
  logic   last_q;

  coord_t end_m1, mnr_step;
  err_t   twice_minor, twice_major, err_step;
  logic   err_pos;

  always_comb begin
    dx     = (start_x_i > end_x_i) ? start_x_i - end_x_i : end_x_i - start_x_i;
    dy     = (start_y_i > end_y_i) ? start_y_i - end_y_i : end_y_i - start_y_i;
    steep  = !(dy < dx);
    swap   = steep ? (start_y_i > end_y_i) : (start_x_i > end_x_i);
    sx     = swap ? end_x_i : start_x_i;
    sy     = swap ? end_y_i : start_y_i;
    ex     = swap ? start_x_i : end_x_i;
    ey     = swap ? start_y_i : end_y_i;
    maj0   = steep ? sy : sx;
    majend = steep ? ey : ex;
    mnr0   = steep ? sx : sy;
    mnrend = steep ? ex : ey;
    mspan  = majend - maj0;
    nspan  = (mnr0 > mnrend) ? mnr0 - mnrend : mnrend - mnr0;
    err0   = err_t'({2'b00, nspan, 1'b0}) - err_t'({3'b000, mspan});
  end

  always_comb begin
    end_m1      = major_end_q - coord_t'(1);
    twice_minor = err_t'({2'b00, minor_span_q, 1'b0});
    twice_major = err_t'({2'b00, major_span_q, 1'b0});
    err_pos     = err_q > err_t'(0);
    err_step    = err_q + twice_minor - (err_pos ? twice_major : err_t'(0));
    if (!err_pos) begin
      mnr_step = mnr_q;
    end else if (minor_negative_q) begin
      mnr_step = mnr_q - coord_t'(1);
    end else begin
      mnr_step = mnr_q + coord_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maj_q            <= '0;
      major_end_q      <= '0;
      mnr_q            <= '0;
      major_span_q     <= '0;
      minor_span_q     <= '0;
      minor_negative_q <= 1'b0;
      steep_line_q     <= 1'b0;
      err_q            <= '0;
    end else if (cmd_i.load) begin
      maj_q            <= maj0;
      major_end_q      <= majend;
      mnr_q            <= mnr0;
      major_span_q     <= mspan;
      minor_span_q     <= nspan;
      minor_negative_q <= (mnrend < mnr0);
      steep_line_q     <= steep;
      err_q            <= err0;
    end else if (cmd_i.step) begin
      maj_q <= maj_q + coord_t'(1);
      mnr_q <= mnr_step;
      err_q <= err_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_x_q <= '0;
      pixel_y_q <= '0;
      last_q    <= 1'b0;
    end else if (cmd_i.step) begin
      pixel_x_q <= steep_line_q ? mnr_q : maj_q;
      pixel_y_q <= steep_line_q ? maj_q : mnr_q;
      last_q    <= (maj_q == end_m1);
    end
  end

  assign status_o.span_zero = (start_x_i == end_x_i) && (start_y_i == end_y_i);
  assign status_o.at_last   = (maj_q == end_m1);

  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign last_pixel_o = last_q;

endmodule

`default_nettype wire

[rtl/blr_ctrl.sv]
// Controller of the line rasterizer: segment load, step sequencing and
// output valid tracking. Depends on blr_pkg.
`default_nettype none

module blr_ctrl
  import blr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire blr_status_t status_i,
  output blr_cmd_t         cmd_o
);

  blr_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.span_zero) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.step = 1'b1;
          if (status_i.at_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.step || (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
